/* rtl/paps_pkg.sv */
// ----------------------------------------------------------------------------
// paps_pkg
// Shared types and command codes for the priority/age scheduler.
// ----------------------------------------------------------------------------
package paps_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_EXIT   = 2'd2;
  localparam logic [1:0] CMD_SETPRI = 2'd3;

  localparam logic [7:0] AGE_MAX  = 8'd255;
  localparam logic [7:0] PID_INIT = 8'd1;
  localparam logic [7:0] PID_NEXT = 8'd2;

  typedef struct packed {
    logic [7:0] pid;
    logic [7:0] priority_v;
    logic [7:0] age;
  } entry_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] target_pid;
    logic [7:0] new_priority;
  } in_item_t;

  typedef struct packed {
    logic [7:0] running_pid;
    logic       switched;
    logic [7:0] new_pid;
    logic       ok;
    logic [6:0] entry_count;
  } out_item_t;

endpackage

/* rtl/paps_cell.sv */
// ----------------------------------------------------------------------------
// paps_cell
// One table slot of the rotating entry ring.
// ----------------------------------------------------------------------------
module paps_cell #(
  parameter logic [23:0] RST_VAL = '0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  paps_pkg::entry_t d_in,
  output paps_pkg::entry_t q
);
  import paps_pkg::*;

  entry_t q_r, q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (shift) begin
      q_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= entry_t'(RST_VAL);
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* rtl/priority_age_process_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_age_process_scheduler
// Process table scheduler: tick, add child, exit and set priority.
// ----------------------------------------------------------------------------
// The table lives in a ring of MAX_PROCS cells that rotates one slot per
// cycle, during the scan and apply states only, past a single head stage. Every
// command takes two full turns of the ring, a gather pass and an update pass,
// plus the finish and idle states. One result item comes out for every input
// item; the next input item is taken while a result still waits.
module priority_age_process_scheduler #(
  parameter int MAX_PROCS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  paps_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output paps_pkg::out_item_t  out_data
);
  import paps_pkg::*;

  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_PROCS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  in_item_t      cmd_r, cmd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [7:0]    nfp_r, nfp_nxt;
  logic [8:0]    best_r, best_nxt;
  logic [SW-1:0] win_r, win_nxt;
  logic          found_r, found_nxt;
  logic [SW-1:0] fslot_r, fslot_nxt;
  entry_t        capc_r, capc_nxt;
  entry_t        capl_r, capl_nxt;
  logic [7:0]    rpid_r, rpid_nxt;
  out_item_t     res_r, res_nxt;
  logic          ov_r, ov_nxt;
  out_item_t     od_r, od_nxt;

  entry_t cells [MAX_PROCS];
  entry_t head_mod;
  logic   shift;

  genvar g;
  generate
    for (g = 0; g < MAX_PROCS; g++) begin : g_cell
      entry_t din;
      if (g == MAX_PROCS - 1) begin : g_tail
        assign din = head_mod;
      end else begin : g_mid
        assign din = cells[g+1];
      end
      paps_cell #(
        .RST_VAL((g == 0) ? {PID_INIT, 16'd0} : 24'd0)
      ) u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .shift(shift),
        .d_in (din),
        .q    (cells[g])
      );
    end
  endgenerate

  entry_t        head;
  logic [CW-1:0] slot_w;
  logic          in_rng;
  logic [CW-1:0] last_w;
  logic [8:0]    sum;
  logic          add_ok, exit_ok;
  logic [SW-1:0] newcur;

  assign head    = cells[0];
  assign slot_w  = CW'(slot_r);
  assign in_rng  = slot_w < cnt_r;
  assign last_w  = cnt_r - CW'(1);
  assign sum     = {1'b0, head.priority_v} + {1'b0, head.age};
  assign add_ok  = cnt_r < CW'(MAX_PROCS);
  assign exit_ok = cnt_r > CW'(1);
  assign shift   = (state_r == ST_SCAN) || (state_r == ST_APPLY);

  always_comb begin
    unique case (cmd_r.command)
      CMD_TICK: newcur = win_r;
      CMD_EXIT: newcur = exit_ok ? '0 : cur_r;
      default:  newcur = cur_r;
    endcase
  end

  always_comb begin
    head_mod = head;
    if (state_r == ST_APPLY) begin
      unique case (cmd_r.command)
        CMD_TICK: begin
          if (in_rng) begin
            if (slot_r != win_r) begin
              if (head.age != AGE_MAX) head_mod.age = head.age + 8'd1;
            end else if (win_r != cur_r) begin
              head_mod.age = '0;
            end
          end
        end
        CMD_ADD: begin
          if (add_ok && slot_w == cnt_r) begin
            head_mod.pid        = nfp_r;
            head_mod.priority_v = capc_r.priority_v;
            head_mod.age        = capc_r.age;
          end
        end
        CMD_EXIT: begin
          if (exit_ok) begin
            if (slot_w == last_w) begin
              head_mod = '0;
            end else if (slot_r == cur_r) begin
              head_mod = capl_r;
            end
          end
        end
        default: begin
          if (found_r && slot_r == fslot_r) head_mod.priority_v = cmd_r.new_priority;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    nfp_nxt   = nfp_r;
    best_nxt  = best_r;
    win_nxt   = win_r;
    found_nxt = found_r;
    fslot_nxt = fslot_r;
    capc_nxt  = capc_r;
    capl_nxt  = capl_r;
    rpid_nxt  = rpid_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          slot_nxt  = '0;
          best_nxt  = '0;
          win_nxt   = '0;
          found_nxt = 1'b0;
          fslot_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (in_rng) begin
          if (sum > best_r) begin
            best_nxt = sum;
            win_nxt  = slot_r;
          end
          if (!found_r && head.pid == cmd_r.target_pid) begin
            found_nxt = 1'b1;
            fslot_nxt = slot_r;
          end
        end
        if (slot_r == cur_r) capc_nxt = head;
        if (slot_w == last_w) capl_nxt = head;
        if (slot_r == SLOT_LAST) begin
          slot_nxt  = '0;
          state_nxt = ST_APPLY;
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      ST_APPLY: begin
        if (slot_r == newcur) rpid_nxt = head_mod.pid;
        if (slot_r == SLOT_LAST) begin
          slot_nxt  = '0;
          state_nxt = ST_FIN;
          res_nxt   = '0;
          unique case (cmd_r.command)
            CMD_TICK: begin
              res_nxt.switched = win_r != cur_r;
              res_nxt.ok       = 1'b1;
              cur_nxt          = win_r;
            end
            CMD_ADD: begin
              if (add_ok) begin
                res_nxt.new_pid = nfp_r;
                res_nxt.ok      = 1'b1;
                nfp_nxt         = nfp_r + 8'd1;
                cnt_nxt         = cnt_r + CW'(1);
              end
            end
            CMD_EXIT: begin
              if (exit_ok) begin
                res_nxt.switched = 1'b1;
                res_nxt.ok       = 1'b1;
                cnt_nxt          = last_w;
                cur_nxt          = '0;
              end
            end
            default: res_nxt.ok = found_r;
          endcase
          res_nxt.entry_count = 7'(cnt_nxt);
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      default: begin
        if (!ov_r || !out_stall) begin
          od_nxt             = res_r;
          od_nxt.running_pid = rpid_r;
          ov_nxt             = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      cnt_r   <= CW'(1);
      cur_r   <= '0;
      nfp_r   <= PID_NEXT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      nfp_r   <= nfp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    best_r  <= best_nxt;
    win_r   <= win_nxt;
    found_r <= found_nxt;
    fslot_r <= fslot_nxt;
    capc_r  <= capc_nxt;
    capl_r  <= capl_nxt;
    rpid_r  <= rpid_nxt;
    res_r   <= res_nxt;
    od_r    <= od_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

/* verif/priority_age_process_scheduler_test.sv */
// ----------------------------------------------------------------------------
// priority_age_process_scheduler_test
// Drives tick, add, exit and set-priority items into the scheduler and checks
// every result item against a behavioral copy of the process table.
// ----------------------------------------------------------------------------
module priority_age_process_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import paps_pkg::*;

  localparam int NPROC = 64;
  localparam int RANDOM_ITEMS = 800;

  typedef struct {
    in_item_t  item;
    bit        has_exp;
    out_item_t exp;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic [7:0] tbl_pid [NPROC];
  logic [7:0] tbl_pri [NPROC];
  logic [7:0] tbl_age [NPROC];
  int         live_count;
  int         cur_slot;
  logic [7:0] pid_counter;

  out_item_t  pending_results[$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         items_sent = 0;
  bit         stall_hold = 1'b0;
  bit         calm = 1'b0;
  int         cmd_hits[4] = '{0, 0, 0, 0};
  int         full_rejects = 0;

  priority_age_process_scheduler #(.MAX_PROCS(NPROC)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  task automatic table_reset();
    for (int i = 0; i < NPROC; i++) begin
      tbl_pid[i] = '0;
      tbl_pri[i] = '0;
      tbl_age[i] = '0;
    end
    tbl_pid[0] = PID_INIT;
    live_count = 1;
    cur_slot = 0;
    pid_counter = PID_NEXT;
  endtask

  function automatic out_item_t schedule_step(in_item_t it);
    out_item_t r;
    int best;
    int win;
    int last;
    r = '0;
    case (it.command)
      CMD_TICK: begin
        best = 0;
        win = 0;
        for (int i = 0; i < live_count; i++) begin
          if (int'(tbl_pri[i]) + int'(tbl_age[i]) > best) begin
            best = int'(tbl_pri[i]) + int'(tbl_age[i]);
            win = i;
          end
        end
        for (int i = 0; i < live_count; i++)
          if (i != win && tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 8'd1;
        if (win != cur_slot) begin
          tbl_age[win] = '0;
          cur_slot = win;
          r.switched = 1'b1;
        end
        r.ok = 1'b1;
      end
      CMD_ADD: begin
        if (live_count < NPROC) begin
          tbl_pid[live_count] = pid_counter;
          tbl_pri[live_count] = tbl_pri[cur_slot];
          tbl_age[live_count] = tbl_age[cur_slot];
          r.new_pid = pid_counter;
          pid_counter = pid_counter + 8'd1;
          live_count++;
          r.ok = 1'b1;
        end
      end
      CMD_EXIT: begin
        if (live_count > 1) begin
          last = live_count - 1;
          if (cur_slot != last) begin
            tbl_pid[cur_slot] = tbl_pid[last];
            tbl_pri[cur_slot] = tbl_pri[last];
            tbl_age[cur_slot] = tbl_age[last];
          end
          tbl_pid[last] = '0;
          tbl_pri[last] = '0;
          tbl_age[last] = '0;
          live_count = last;
          cur_slot = 0;
          r.switched = 1'b1;
          r.ok = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < live_count; i++) begin
          if (tbl_pid[i] == it.target_pid) begin
            tbl_pri[i] = it.new_priority;
            r.ok = 1'b1;
            break;
          end
        end
      end
    endcase
    r.running_pid = tbl_pid[cur_slot];
    r.entry_count = 7'(live_count);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch result %0d %s: got %0d expected %0d", results_seen, what, got, want);
  endtask

  task automatic send_item(in_item_t it, bit has_exp = 1'b0, out_item_t fixed = '0);
    out_item_t e;
    if (!calm) begin
      while ($urandom_range(99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    if (it.command == CMD_ADD && live_count == NPROC) full_rejects++;
    e = schedule_step(it);
    if (has_exp && e !== fixed)
      report("typed row vs predictor", 32'(fixed), 32'(e));
    cmd_hits[it.command]++;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(e);
    items_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected item", 32'(out_data), 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_data.running_pid !== w.running_pid)
          report("running_pid", 32'(out_data.running_pid), 32'(w.running_pid));
        if (out_data.switched !== w.switched)
          report("switched", 32'(out_data.switched), 32'(w.switched));
        if (out_data.new_pid !== w.new_pid)
          report("new_pid", 32'(out_data.new_pid), 32'(w.new_pid));
        if (out_data.ok !== w.ok) report("ok", 32'(out_data.ok), 32'(w.ok));
        if (out_data.entry_count !== w.entry_count)
          report("entry_count", 32'(out_data.entry_count), 32'(w.entry_count));
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (stall_hold) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 7);
  end

  function automatic in_item_t mk(logic [1:0] c, logic [7:0] p = '0, logic [7:0] v = '0);
    in_item_t it;
    it.command = c;
    it.target_pid = p;
    it.new_priority = v;
    return it;
  endfunction

  function automatic out_item_t res(logic [7:0] rp, logic sw, logic [7:0] np, logic k,
                                    logic [6:0] n);
    out_item_t r;
    r.running_pid = rp;
    r.switched = sw;
    r.new_pid = np;
    r.ok = k;
    r.entry_count = n;
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    in_item_t it;
    int pick;
    int hold_cycles;

    table_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    rows.push_back('{mk(CMD_TICK), 1'b1, res(8'd1, 1'b0, 8'd0, 1'b1, 7'd1)});
    rows.push_back('{mk(CMD_EXIT), 1'b1, res(8'd1, 1'b0, 8'd0, 1'b0, 7'd1)});
    rows.push_back('{mk(CMD_SETPRI, 8'd9, 8'd5), 1'b1, res(8'd1, 1'b0, 8'd0, 1'b0, 7'd1)});
    rows.push_back('{mk(CMD_SETPRI, 8'd1, 8'd255), 1'b1, res(8'd1, 1'b0, 8'd0, 1'b1, 7'd1)});
    rows.push_back('{mk(CMD_ADD), 1'b1, res(8'd1, 1'b0, 8'd2, 1'b1, 7'd2)});
    rows.push_back('{mk(CMD_ADD), 1'b1, res(8'd1, 1'b0, 8'd3, 1'b1, 7'd3)});
    rows.push_back('{mk(CMD_SETPRI, 8'd3, 8'd0), 1'b0, '0});
    rows.push_back('{mk(CMD_SETPRI, 8'd1, 8'd0), 1'b0, '0});
    rows.push_back('{mk(CMD_SETPRI, 8'd2, 8'd0), 1'b0, '0});
    rows.push_back('{mk(CMD_TICK), 1'b0, '0});
    rows.push_back('{mk(CMD_TICK), 1'b0, '0});
    rows.push_back('{mk(CMD_SETPRI, 8'd3, 8'd255), 1'b0, '0});
    rows.push_back('{mk(CMD_TICK), 1'b0, '0});
    rows.push_back('{mk(CMD_EXIT), 1'b0, '0});
    rows.push_back('{mk(CMD_SETPRI, 8'hAA, 8'h55), 1'b0, '0});
    rows.push_back('{mk(CMD_SETPRI, 8'h55, 8'hAA), 1'b0, '0});
    rows.push_back('{mk(CMD_EXIT), 1'b0, '0});
    rows.push_back('{mk(CMD_TICK), 1'b0, '0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_exp, rows[i].exp);

    // fill the table to reject an add
    repeat (NPROC + 2) send_item(mk(CMD_ADD, 8'($urandom), 8'($urandom)));
    repeat (300) send_item(mk(CMD_TICK));

    // long receiver hold while the sender keeps offering
    fork
      begin
        stall_hold = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 600) begin
          @(posedge clk);
          hold_cycles++;
        end
        stall_hold = 1'b0;
      end
      repeat (8) send_item(mk(CMD_SETPRI, 8'($urandom), 8'($urandom)));
    join
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 300 && n < 450);
      pick = $urandom_range(99);
      if (pick < 35) it = mk(CMD_TICK, 8'($urandom), 8'($urandom));
      else if (pick < 55) it = mk(CMD_ADD, 8'($urandom), 8'($urandom));
      else if (pick < 70) it = mk(CMD_EXIT, 8'($urandom), 8'($urandom));
      else if (pick < 90 && live_count > 0)
        it = mk(CMD_SETPRI, tbl_pid[$urandom_range(live_count - 1)], 8'($urandom));
      else it = mk(CMD_SETPRI, 8'($urandom), 8'($urandom));
      send_item(it);
      if (n == 600) drain();
    end
    calm = 1'b0;

    drain();
    repeat (400) @(posedge clk);
    $display("sent %0d items (tick %0d, add %0d, exit %0d, setpri %0d), %0d results",
             items_sent, cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3], results_seen);
    $display("full-table adds %0d, leftover expectations %0d", full_rejects,
             pending_results.size());
    if (pending_results.size() != 0)
      report("missing results", 32'(pending_results.size()), 32'd0);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
